[rtl/mset_pkg.sv]
package mset_pkg;

  // Table geometry
  localparam int SLOTS    = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_FIRE = 8;
  localparam int NFIRE_W  = $clog2(MAX_FIRE + 1);

  // Timing constants
  localparam logic [7:0]  REP_PERIOD_MAX = 8'd255;
  localparam logic [31:0] DUE_NEVER      = 32'hFFFF_FFFF;
  localparam logic [2:0]  JIT_LAST       = 3'd6;  // now mod 7 runs 0..6

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_REG   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Slot modes
  localparam logic [2:0] MODE_SINGLE     = 3'd0;
  localparam logic [2:0] MODE_SINGLE_IMM = 3'd1;
  localparam logic [2:0] MODE_PERIOD     = 3'd2;
  localparam logic [2:0] MODE_PERIOD_IMM = 3'd3;
  localparam logic [2:0] MODE_REP        = 3'd4;
  localparam logic [2:0] MODE_REP_IMM    = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADMODE = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  handler;
    logic [3:0]  label;
    logic [2:0]  mode;
    logic [15:0] period;
    logic [7:0]  runs;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [2:0] slot;
    logic [7:0] fired_handler;
    logic [3:0] fired_label;
    logic       last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // take the input transaction
    logic tick_start;  // advance time, start a scan
    logic reg_emit;    // finish a register command
    logic clr_emit;    // finish a clear command
    logic scan_step;   // examine the current slot
    logic flush_emit;  // send the held result as the last one
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic hit;
    logic held_v;
    logic scan_last;
  } ctl_sts_t;

  // Low three bits of a slot index for the result field
  function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+2:0] ext;
    ext = {3'b000, idx};
    return ext[2:0];
  endfunction

endpackage

[rtl/multi_slot_event_timer.sv]
// Channel   Direction  Payload     Handshake
// in_       input      in_item_t   in_valid / in_stall
// out_      output     out_item_t  out_valid / out_stall
//
// A tick is accepted, then scans one slot per cycle unless an output stall holds the scan,
// then sends the held result, if any, as the last; the single compare-and-update unit steps the table.
// Register and clear send one result once the output is free; an unused command sends none.
// Synchronous active-low reset empties every slot and zeroes the millisecond counter.
// Output stalls pause the scan only when a second fired result must leave; the input is
// stalled from acceptance of a tick, register or clear until its last result is loaded.
module multi_slot_event_timer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mset_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mset_pkg::out_item_t out_data
);
  import mset_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  mset_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  mset_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/mset_ctrl.sv]
module mset_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  input  mset_pkg::ctl_sts_t sts,
  output logic              in_stall,
  output mset_pkg::ctl_cmd_t cmd
);
  import mset_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REG   = 3'd1;
  localparam logic [2:0] S_CLR   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       step_ok;

  // A firing slot may only displace the held result into a free output register
  assign step_ok = !(sts.hit && sts.held_v && !sts.out_free);
  // No transaction is taken while in reset
  assign in_stall = !rst_n || (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_cmd)
            CMD_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = S_SCAN;
            end
            CMD_REG:   state_nxt = S_REG;
            CMD_CLEAR: state_nxt = S_CLR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_REG: begin
        if (sts.out_free) begin
          cmd.reg_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CLR: begin
        if (sts.out_free) begin
          cmd.clr_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (step_ok) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.held_v) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush_emit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[rtl/mset_dp.sv]
module mset_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mset_pkg::in_item_t  in_data,
  input  logic                out_stall,
  input  mset_pkg::ctl_cmd_t  cmd,
  output mset_pkg::ctl_sts_t  sts,
  output logic                out_valid,
  output mset_pkg::out_item_t out_data
);
  import mset_pkg::*;

  // Time base
  logic [31:0] now_r;
  logic [2:0]  jit_r;   // now_r mod 7

  // Slot table
  logic [3:0]  lbl_r  [SLOTS];
  logic [2:0]  mode_r [SLOTS];
  logic [15:0] ctx_r  [SLOTS];
  logic [31:0] due_r  [SLOTS];
  logic [7:0]  hnd_r  [SLOTS];

  // Scan and result staging
  in_item_t          item_r;
  logic [SLOT_W-1:0] idx_r;
  logic [NFIRE_W-1:0] nfire_r;
  out_item_t         held_r;
  logic              held_v_r;
  out_item_t         out_r;
  logic              out_v_r;

  logic              found;
  logic [SLOT_W-1:0] fidx;
  logic              mode_ok;
  logic              reg_ok;
  logic [7:0]        rep_per;
  logic [15:0]       reg_ctx;
  logic [31:0]       reg_due;
  logic              hit;
  logic [7:0]        cur_cnt;
  logic              out_ld;
  out_item_t         out_nxt;
  out_item_t         fire_res;

  // Lowest-numbered empty slot
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (lbl_r[i] == 4'd0) begin
        found = 1'b1;
        fidx  = SLOT_W'(i);
      end
    end
  end

  // Register command: context and first due time
  always_comb begin
    mode_ok = (item_r.mode <= MODE_REP_IMM);
    reg_ok  = mode_ok && found;
    rep_per = (item_r.period > 16'(REP_PERIOD_MAX)) ? REP_PERIOD_MAX : item_r.period[7:0];
    if (item_r.mode inside {MODE_REP, MODE_REP_IMM}) reg_ctx = {item_r.runs, rep_per};
    else                                             reg_ctx = item_r.period;
    case (item_r.mode)
      MODE_SINGLE:             reg_due = now_r + 32'(jit_r) + 32'(reg_ctx);
      MODE_SINGLE_IMM:         reg_due = now_r + 32'(reg_ctx);
      MODE_PERIOD, MODE_REP:   reg_due = now_r + 32'(jit_r);
      default:                 reg_due = now_r;
    endcase
  end

  // Current scan slot
  assign hit     = (lbl_r[idx_r] != 4'd0) && (due_r[idx_r] <= now_r)
                   && (nfire_r < NFIRE_W'(MAX_FIRE));
  assign cur_cnt = ctx_r[idx_r][15:8];

  always_comb begin
    fire_res               = '0;
    fire_res.status        = ST_OK;
    fire_res.fired         = 1'b1;
    fire_res.slot          = slot_field(idx_r);
    fire_res.fired_handler = hnd_r[idx_r];
    fire_res.fired_label   = lbl_r[idx_r];
  end

  assign sts.out_free  = !out_v_r || !out_stall;
  assign sts.hit       = hit;
  assign sts.held_v    = held_v_r;
  assign sts.scan_last = (idx_r == SLOT_W'(SLOTS - 1));

  // Output register load
  always_comb begin
    out_ld  = 1'b0;
    out_nxt = held_r;
    if (cmd.reg_emit) begin
      out_ld  = 1'b1;
      out_nxt = '0;
      out_nxt.last = 1'b1;
      if (!mode_ok) begin
        out_nxt.status = ST_BADMODE;
      end else if (!found) begin
        out_nxt.status = ST_FULL;
      end else begin
        out_nxt.status = ST_OK;
        out_nxt.slot   = slot_field(fidx);
      end
    end else if (cmd.clr_emit) begin
      out_ld  = 1'b1;
      out_nxt = '0;
      out_nxt.last = 1'b1;
    end else if (cmd.flush_emit) begin
      out_ld  = 1'b1;
      out_nxt.last = 1'b1;
    end else if (cmd.scan_step && hit && held_v_r) begin
      out_ld  = 1'b1;
      out_nxt.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Input transaction capture
  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_data;
  end

  // Millisecond counter and its residue mod 7 (2^32 is 4 mod 7, so wrap resets it)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      jit_r <= '0;
    end else if (cmd.tick_start) begin
      now_r <= now_r + 32'd1;
      if (now_r == DUE_NEVER || jit_r == JIT_LAST) jit_r <= '0;
      else                                         jit_r <= jit_r + 3'd1;
    end
  end

  // Scan control and held result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      nfire_r  <= '0;
      held_v_r <= 1'b0;
    end else if (cmd.tick_start) begin
      idx_r    <= '0;
      nfire_r  <= '0;
      held_v_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (idx_r != SLOT_W'(SLOTS - 1)) idx_r <= idx_r + SLOT_W'(1);
      if (hit) begin
        nfire_r  <= nfire_r + NFIRE_W'(1);
        held_v_r <= 1'b1;
      end
    end else if (cmd.flush_emit) begin
      held_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && hit) held_r <= fire_res;
  end

  // Slot table updates
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_emit) begin
      for (int i = 0; i < SLOTS; i++) begin
        lbl_r[i]  <= '0;
        mode_r[i] <= '0;
        ctx_r[i]  <= '0;
        due_r[i]  <= DUE_NEVER;
        hnd_r[i]  <= '0;
      end
    end else if (cmd.reg_emit && reg_ok) begin
      lbl_r[fidx]  <= item_r.label;
      mode_r[fidx] <= item_r.mode;
      ctx_r[fidx]  <= reg_ctx;
      due_r[fidx]  <= reg_due;
      hnd_r[fidx]  <= item_r.handler;
    end else if (cmd.scan_step && hit) begin
      case (mode_r[idx_r])
        MODE_PERIOD, MODE_PERIOD_IMM: begin
          mode_r[idx_r] <= MODE_PERIOD;
          due_r[idx_r]  <= now_r + 32'(ctx_r[idx_r]);
        end
        MODE_REP, MODE_REP_IMM: begin
          // Count down; the last run turns the slot into a one-shot
          if (cur_cnt > 8'd1) begin
            mode_r[idx_r] <= MODE_REP;
            ctx_r[idx_r]  <= {cur_cnt - 8'd1, ctx_r[idx_r][7:0]};
          end else begin
            mode_r[idx_r] <= MODE_SINGLE;
            ctx_r[idx_r]  <= {8'd0, ctx_r[idx_r][7:0]};
          end
          due_r[idx_r] <= now_r + 32'(ctx_r[idx_r][7:0]);
        end
        default: begin
          lbl_r[idx_r]  <= '0;
          mode_r[idx_r] <= '0;
          ctx_r[idx_r]  <= '0;
          due_r[idx_r]  <= DUE_NEVER;
          hnd_r[idx_r]  <= '0;
        end
      endcase
    end
  end

endmodule

[rtl/mset_checker.sv]
module mset_sva (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mset_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mset_pkg::out_item_t out_data
);
  import mset_pkg::*;

  // A stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // One transaction at a time: input stalls right after acceptance of any real command
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd != CMD_NOP) |=> in_stall)
    else $error("input accepted while busy");

  // More results pending for the current transaction keep the input stalled
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input free before last result");

  // Register and clear results are single and final
  a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fired |-> out_data.last && out_data.fired_label == 4'd0)
    else $error("non-fired result not final");

endmodule

bind multi_slot_event_timer mset_sva u_mset_sva (.*);
